@@ rtl/rgbcf_pkg.sv @@
// Package for the RGB pixel color filter: payload types, mode codes and coefficients.
package rgbcf_pkg;

   typedef struct packed {
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [11:0] pixel_row;
      logic [11:0] pixel_col;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int MODE_W      = 4;
   localparam int DIM_REG_W   = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_PASS          = 4'd0;
   localparam logic [MODE_W-1:0] MODE_THRESH_SUB    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_BRIGHT_WARM   = 4'd2;
   localparam logic [MODE_W-1:0] MODE_GRAY          = 4'd3;
   localparam logic [MODE_W-1:0] MODE_SEPIA         = 4'd4;
   localparam logic [MODE_W-1:0] MODE_COOL          = 4'd5;
   localparam logic [MODE_W-1:0] MODE_WARM          = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BANDS         = 4'd7;
   localparam logic [MODE_W-1:0] MODE_FRAME         = 4'd8;
   localparam logic [MODE_W-1:0] MODE_CONTRAST_TINT = 4'd9;
   localparam logic [MODE_W-1:0] MODE_CONTRAST_BLUE = 4'd10;
   localparam logic [MODE_W-1:0] MODE_RED_BOOST     = 4'd11;
   localparam logic [MODE_W-1:0] MODE_GREEN_BOOST   = 4'd12;
   localparam logic [MODE_W-1:0] MODE_BLUE_RED      = 4'd13;

   localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Q10 sepia coefficients, output channel then input channel
   localparam logic [9:0] SEPIA_R_R = 10'd402;
   localparam logic [9:0] SEPIA_R_G = 10'd787;
   localparam logic [9:0] SEPIA_R_B = 10'd194;
   localparam logic [9:0] SEPIA_G_R = 10'd357;
   localparam logic [9:0] SEPIA_G_G = 10'd702;
   localparam logic [9:0] SEPIA_G_B = 10'd172;
   localparam logic [9:0] SEPIA_B_R = 10'd279;
   localparam logic [9:0] SEPIA_B_G = 10'd547;
   localparam logic [9:0] SEPIA_B_B = 10'd134;

   // floor(s/3) = (s*683)>>11 for s <= 765
   localparam logic [9:0]  DIV3_MUL   = 10'd683;
   // floor(row/20) = (row*3277)>>16 for row <= 4095
   localparam logic [11:0] DIV20_MUL  = 12'd3277;

   localparam logic [7:0] CONTRAST_KNEE = 8'd127;
   localparam logic [7:0] THRESH_SUB    = 8'd100;
   localparam logic [7:0] THRESH_BRIGHT = 8'd205;
   localparam logic [4:0] BAND_PERIOD   = 5'd20;
   localparam logic [4:0] BAND_LAST_ROW = 5'd5;
   localparam logic [7:0] FRAME_LEFT    = 8'd55;
   localparam logic [7:0] FRAME_TOP     = 8'd55;
   localparam logic [7:0] FRAME_RIGHT   = 8'd55;
   localparam logic [7:0] FRAME_BOTTOM  = 8'd155;

endpackage

@@ rtl/rgb_pixel_color_filter_top.sv @@
// Top level of the RGB pixel color filter: three-stage pixel pipeline and CSRs.
// An accepted req transaction passes through the register stages s1, s2 and rsp to rsp_valid.
// Throughput: one pixel per cycle while rsp_stall is low; each of the three register stages holds one pixel.
// Stage 1 forms products and row quotient, stage 2 sums, gray quotient and band test, stage 3 mux and clamp.
// Reset (synchronous): clears all stage valid bits, mode 0, width 640, height 480.
module rgb_pixel_color_filter_top #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rgbcf_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rgbcf_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_write_en,
   input  logic [rgbcf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rgbcf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (LIM_W > rgbcf_pkg::DIM_REG_W) ? LIM_W : rgbcf_pkg::DIM_REG_W;
   localparam int SUM_W = CMP_W + 1;

   typedef struct packed {
      logic [7:0]       r;
      logic [7:0]       g;
      logic [7:0]       b;
      logic [7:0]       cr;
      logic [7:0]       cg;
      logic [7:0]       cb;
      logic [11:0]      row;
      logic [9:0]       sum3;
      logic [7:0]       q20;
      logic             interior;
      logic [8:0][17:0] prod;
   } s1_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] cr;
      logic [7:0] cg;
      logic [7:0] cb;
      logic [7:0] gray;
      logic [8:0] sep_r;
      logic [8:0] sep_g;
      logic [8:0] sep_b;
      logic       band;
      logic       interior;
   } s2_type;

   logic [rgbcf_pkg::MODE_W-1:0]    mode_ff;
   logic [rgbcf_pkg::DIM_REG_W-1:0] width_ff;
   logic [rgbcf_pkg::DIM_REG_W-1:0] height_ff;

   logic               s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   rgbcf_pkg::rsp_type rsp_ff, rsp_in;
   logic               ready1, ready2, ready3;

   logic [CMP_W-1:0] dim_w, dim_h;
   logic [11:0]      rem20;
   logic [23:0]      q20_prod;
   logic [19:0]      gray_prod;
   logic [18:0]      sum_r, sum_g, sum_b;
   logic signed [10:0] nr, ng, nb;

   function automatic logic [7:0] contrast(input logic [7:0] v);
      return (v > rgbcf_pkg::CONTRAST_KNEE) ? 8'hFF : {v[6:0], 1'b0};
   endfunction

   function automatic logic signed [10:0] ext(input logic [8:0] v);
      return signed'({2'b00, v});
   endfunction

   function automatic logic signed [10:0] over_th(input logic [7:0] v,
                                                  input logic signed [10:0] add);
      return (v > rgbcf_pkg::THRESH_BRIGHT) ? 11'sd255 : ext({1'b0, v}) + add;
   endfunction

   function automatic logic [7:0] clamp8(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 11'sd0) begin
         res = 8'd0;
      end else if (v > 11'sd255) begin
         res = 8'hFF;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rgbcf_pkg::MODE_PASS;
         width_ff  <= rgbcf_pkg::WIDTH_RESET;
         height_ff <= rgbcf_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rgbcf_pkg::CSR_FILTER_MODE:  mode_ff   <= csr_wdata[rgbcf_pkg::MODE_W-1:0];
            rgbcf_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            rgbcf_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dim_w = (CMP_W'(width_ff) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(width_ff);
   assign dim_h = (CMP_W'(height_ff) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : CMP_W'(height_ff);

   assign ready3    = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   // stage 1: products, contrast, frame test
   always_comb begin
      s1_in.r    = req_data.red_in;
      s1_in.g    = req_data.green_in;
      s1_in.b    = req_data.blue_in;
      s1_in.cr   = contrast(req_data.red_in);
      s1_in.cg   = contrast(req_data.green_in);
      s1_in.cb   = contrast(req_data.blue_in);
      s1_in.row  = req_data.pixel_row;
      s1_in.sum3 = 10'(req_data.red_in) + 10'(req_data.green_in) + 10'(req_data.blue_in);
      q20_prod   = 24'(req_data.pixel_row) * 24'(rgbcf_pkg::DIV20_MUL);
      s1_in.q20  = q20_prod[23:16];
      s1_in.interior =
         (req_data.pixel_row >= 12'(rgbcf_pkg::FRAME_TOP)) &&
         (SUM_W'(req_data.pixel_row) + SUM_W'(rgbcf_pkg::FRAME_BOTTOM) < SUM_W'(dim_h)) &&
         (req_data.pixel_col >= 12'(rgbcf_pkg::FRAME_LEFT)) &&
         (SUM_W'(req_data.pixel_col) + SUM_W'(rgbcf_pkg::FRAME_RIGHT) < SUM_W'(dim_w));
      s1_in.prod[0] = 18'(req_data.red_in)   * 18'(rgbcf_pkg::SEPIA_R_R);
      s1_in.prod[1] = 18'(req_data.green_in) * 18'(rgbcf_pkg::SEPIA_R_G);
      s1_in.prod[2] = 18'(req_data.blue_in)  * 18'(rgbcf_pkg::SEPIA_R_B);
      s1_in.prod[3] = 18'(req_data.red_in)   * 18'(rgbcf_pkg::SEPIA_G_R);
      s1_in.prod[4] = 18'(req_data.green_in) * 18'(rgbcf_pkg::SEPIA_G_G);
      s1_in.prod[5] = 18'(req_data.blue_in)  * 18'(rgbcf_pkg::SEPIA_G_B);
      s1_in.prod[6] = 18'(req_data.red_in)   * 18'(rgbcf_pkg::SEPIA_B_R);
      s1_in.prod[7] = 18'(req_data.green_in) * 18'(rgbcf_pkg::SEPIA_B_G);
      s1_in.prod[8] = 18'(req_data.blue_in)  * 18'(rgbcf_pkg::SEPIA_B_B);
   end

   // stage 2: sepia sums, grayscale quotient, band remainder
   always_comb begin
      sum_r     = 19'(s1_ff.prod[0]) + 19'(s1_ff.prod[1]) + 19'(s1_ff.prod[2]);
      sum_g     = 19'(s1_ff.prod[3]) + 19'(s1_ff.prod[4]) + 19'(s1_ff.prod[5]);
      sum_b     = 19'(s1_ff.prod[6]) + 19'(s1_ff.prod[7]) + 19'(s1_ff.prod[8]);
      gray_prod = 20'(s1_ff.sum3) * 20'(rgbcf_pkg::DIV3_MUL);
      rem20     = s1_ff.row - ({4'd0, s1_ff.q20} << 4) - ({4'd0, s1_ff.q20} << 2);
      s2_in.r      = s1_ff.r;
      s2_in.g      = s1_ff.g;
      s2_in.b      = s1_ff.b;
      s2_in.cr     = s1_ff.cr;
      s2_in.cg     = s1_ff.cg;
      s2_in.cb     = s1_ff.cb;
      s2_in.gray   = gray_prod[18:11];
      s2_in.sep_r  = sum_r[18:10];
      s2_in.sep_g  = sum_g[18:10];
      s2_in.sep_b  = sum_b[18:10];
      s2_in.band   = (rem20 <= 12'(rgbcf_pkg::BAND_LAST_ROW));
      s2_in.interior = s1_ff.interior;
   end

   // stage 3: effect select and clamp
   always_comb begin
      nr = ext({1'b0, s2_ff.r});
      ng = ext({1'b0, s2_ff.g});
      nb = ext({1'b0, s2_ff.b});
      unique case (mode_ff)
         rgbcf_pkg::MODE_THRESH_SUB: begin
            if (s2_ff.r > rgbcf_pkg::THRESH_SUB) nr = ext({1'b0, s2_ff.r}) - 11'sd30;
            if (s2_ff.g > rgbcf_pkg::THRESH_SUB) ng = ext({1'b0, s2_ff.g}) - 11'sd35;
            if (s2_ff.b > rgbcf_pkg::THRESH_SUB) nb = ext({1'b0, s2_ff.b}) - 11'sd25;
         end
         rgbcf_pkg::MODE_BRIGHT_WARM: begin
            nr = over_th(s2_ff.r, 11'sd10);
            ng = over_th(s2_ff.g, 11'sd25);
            nb = over_th(s2_ff.b, -11'sd5);
         end
         rgbcf_pkg::MODE_GRAY: begin
            nr = ext({1'b0, s2_ff.gray});
            ng = ext({1'b0, s2_ff.gray});
            nb = ext({1'b0, s2_ff.gray});
         end
         rgbcf_pkg::MODE_SEPIA: begin
            nr = ext(s2_ff.sep_r);
            ng = ext(s2_ff.sep_g);
            nb = ext(s2_ff.sep_b);
         end
         rgbcf_pkg::MODE_COOL: begin
            nr = ext({1'b0, s2_ff.r}) - 11'sd10;
            ng = ext({1'b0, s2_ff.g}) - 11'sd10;
            nb = ext({1'b0, s2_ff.b}) + 11'sd10;
         end
         rgbcf_pkg::MODE_WARM: begin
            nr = ext({1'b0, s2_ff.r}) + 11'sd20;
            ng = ext({1'b0, s2_ff.g}) + 11'sd5;
            nb = ext({1'b0, s2_ff.b}) - 11'sd10;
         end
         rgbcf_pkg::MODE_BANDS: begin
            if (s2_ff.band) begin
               nr = ext({1'b0, s2_ff.r}) + 11'sd20;
               ng = ext({1'b0, s2_ff.g}) + 11'sd10;
               nb = ext({1'b0, s2_ff.b}) - 11'sd10;
            end
         end
         rgbcf_pkg::MODE_FRAME: begin
            if (s2_ff.interior) begin
               nr = ext({1'b0, s2_ff.r}) - 11'sd30;
               ng = ext({1'b0, s2_ff.g}) - 11'sd30;
               nb = ext({1'b0, s2_ff.b}) - 11'sd20;
            end else begin
               nr = 11'sd255;
               ng = 11'sd255;
               nb = 11'sd255;
            end
         end
         rgbcf_pkg::MODE_CONTRAST_TINT: begin
            nr = ext({1'b0, s2_ff.cr}) + 11'sd50;
            ng = ext({1'b0, s2_ff.cg}) + 11'sd25;
            nb = ext({1'b0, s2_ff.cb}) - 11'sd25;
         end
         rgbcf_pkg::MODE_CONTRAST_BLUE: begin
            nr = ext({1'b0, s2_ff.cr});
            ng = ext({1'b0, s2_ff.cg});
            nb = ext({1'b0, s2_ff.cb}) + 11'sd50;
         end
         rgbcf_pkg::MODE_RED_BOOST: begin
            nr = ext({1'b0, s2_ff.r}) + 11'sd50;
         end
         rgbcf_pkg::MODE_GREEN_BOOST: begin
            ng = ext({1'b0, s2_ff.g}) + 11'sd50;
         end
         rgbcf_pkg::MODE_BLUE_RED: begin
            nr = ext({1'b0, s2_ff.r}) - 11'sd50;
            nb = ext({1'b0, s2_ff.b}) + 11'sd150;
         end
         default: ;
      endcase
      rsp_in.red_out   = clamp8(nr);
      rsp_in.green_out = clamp8(ng);
      rsp_in.blue_out  = clamp8(nb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) s1_valid_ff <= req_valid;
         if (ready2) s2_valid_ff <= s1_valid_ff;
         if (ready3) rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) s1_ff <= s1_in;
      if (ready2 && s1_valid_ff) s2_ff <= s2_in;
      if (ready3 && s2_valid_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled while a pipeline stage is empty");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !ready2) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stage 1 transaction lost or changed during stall");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !ready3) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("stage 2 transaction lost or changed during stall");

   a_rem20_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (rem20 < 12'(rgbcf_pkg::BAND_PERIOD)))
      else $error("row remainder out of range");
`endif

endmodule

@@ test/tb_rgb_pixel_color_filter_top.sv @@
// Self-checking testbench for the RGB pixel color filter: directed table, random phases, predictor.
module tb_rgb_pixel_color_filter_top;
   import rgbcf_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DIM_LIMIT    = 4096;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASES       = 18;
   localparam int PHASE_ITEMS  = 79;
   localparam int DIRECTED_N   = 25;

   localparam logic [MODE_W-1:0]      MODE_UNUSED_14 = 4'd14;
   localparam logic [MODE_W-1:0]      MODE_UNUSED_15 = 4'd15;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED     = 2'd3;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [DIM_REG_W-1:0] width;
      logic [DIM_REG_W-1:0] height;
      req_type              px;
      bit                   typed;
      rsp_type              want;
   } pixel_case_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [MODE_W-1:0]      cur_mode;
   logic [DIM_REG_W-1:0]   cur_width;
   logic [DIM_REG_W-1:0]   cur_height;

   rsp_type pending_pixels[$];
   int      mismatch_count;
   int      checked_count;
   int      setting_count;
   int      cycle_count;
   bit      req_idle;
   bit      rsp_idle;
   bit      hold_rsp_req;

   pixel_case_t directed_cases [DIRECTED_N] = '{
      '{MODE_PASS, 13'd640, 13'd480, '{8'd12, 8'd200, 8'd255, 12'd0, 12'd0},
        1'b1, '{8'd12, 8'd200, 8'd255}},
      '{MODE_PASS, 13'd640, 13'd480, '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095},
        1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MODE_THRESH_SUB, 13'd640, 13'd480, '{8'd101, 8'd100, 8'd255, 12'd7, 12'd9},
        1'b1, '{8'd71, 8'd100, 8'd230}},
      '{MODE_BRIGHT_WARM, 13'd640, 13'd480, '{8'd206, 8'd205, 8'd0, 12'd0, 12'd0},
        1'b1, '{8'd255, 8'd230, 8'd0}},
      '{MODE_GRAY, 13'd640, 13'd480, '{8'd255, 8'd255, 8'd255, 12'd0, 12'd0},
        1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MODE_SEPIA, 13'd640, 13'd480, '{8'd0, 8'd0, 8'd0, 12'd0, 12'd0},
        1'b1, '{8'd0, 8'd0, 8'd0}},
      '{MODE_SEPIA, 13'd640, 13'd480, '{8'd255, 8'd255, 8'd255, 12'd1, 12'd1},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_COOL, 13'd640, 13'd480, '{8'd5, 8'd255, 8'd250, 12'd2, 12'd3},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_WARM, 13'd640, 13'd480, '{8'd255, 8'd0, 8'd5, 12'd4, 12'd5},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_BANDS, 13'd640, 13'd480, '{8'd100, 8'd100, 8'd100, 12'd5, 12'd0},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_BANDS, 13'd640, 13'd480, '{8'd100, 8'd100, 8'd100, 12'd6, 12'd0},
        1'b1, '{8'd100, 8'd100, 8'd100}},
      '{MODE_FRAME, 13'd640, 13'd480, '{8'd10, 8'd20, 8'd30, 12'd54, 12'd100},
        1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MODE_FRAME, 13'd640, 13'd480, '{8'd10, 8'd200, 8'd30, 12'd55, 12'd55},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_FRAME, 13'd640, 13'd480, '{8'd40, 8'd40, 8'd40, 12'd324, 12'd584},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_FRAME, 13'd640, 13'd480, '{8'd40, 8'd40, 8'd40, 12'd325, 12'd300},
        1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MODE_FRAME, 13'd0, 13'd4096, '{8'd10, 8'd20, 8'd30, 12'd100, 12'd100},
        1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MODE_FRAME, 13'd8191, 13'd8191, '{8'd90, 8'd90, 8'd90, 12'd3940, 12'd4040},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_FRAME, 13'd8191, 13'd8191, '{8'd90, 8'd90, 8'd90, 12'd3941, 12'd4040},
        1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MODE_CONTRAST_TINT, 13'd8191, 13'd8191, '{8'd127, 8'd128, 8'd0, 12'd0, 12'd0},
        1'b1, '{8'd255, 8'd255, 8'd0}},
      '{MODE_CONTRAST_BLUE, 13'd8191, 13'd8191, '{8'd0, 8'd64, 8'd255, 12'd0, 12'd0},
        1'b1, '{8'd0, 8'd128, 8'd255}},
      '{MODE_RED_BOOST, 13'd8191, 13'd8191, '{8'd255, 8'd1, 8'd2, 12'd0, 12'd0},
        1'b1, '{8'd255, 8'd1, 8'd2}},
      '{MODE_GREEN_BOOST, 13'd8191, 13'd8191, '{8'd3, 8'd100, 8'd4, 12'd0, 12'd0},
        1'b0, '{8'd0, 8'd0, 8'd0}},
      '{MODE_BLUE_RED, 13'd8191, 13'd8191, '{8'd0, 8'd0, 8'd105, 12'd0, 12'd0},
        1'b1, '{8'd0, 8'd0, 8'd255}},
      '{MODE_UNUSED_14, 13'd8191, 13'd8191, '{8'd1, 8'd2, 8'd3, 12'd0, 12'd0},
        1'b1, '{8'd1, 8'd2, 8'd3}},
      '{MODE_UNUSED_15, 13'd8191, 13'd8191, '{8'd255, 8'd0, 8'd128, 12'd0, 12'd0},
        1'b1, '{8'd255, 8'd0, 8'd128}}
   };

   rgb_pixel_color_filter_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] clamp_channel(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   function automatic int contrast_boost(int v);
      return (v > 127) ? 255 : 2 * v;
   endfunction

   function automatic rsp_type filter_pixel(req_type px, logic [MODE_W-1:0] mode,
                                            logic [DIM_REG_W-1:0] wreg,
                                            logic [DIM_REG_W-1:0] hreg);
      int      r, g, b, row, col, w, h, nr, ng, nb;
      rsp_type res;
      r = px.red_in;
      g = px.green_in;
      b = px.blue_in;
      row = px.pixel_row;
      col = px.pixel_col;
      w = (wreg > DIM_LIMIT) ? DIM_LIMIT : int'(wreg);
      h = (hreg > DIM_LIMIT) ? DIM_LIMIT : int'(hreg);
      nr = r;
      ng = g;
      nb = b;
      case (mode)
         MODE_THRESH_SUB: begin
            if (r > 100) nr = r - 30;
            if (g > 100) ng = g - 35;
            if (b > 100) nb = b - 25;
         end
         MODE_BRIGHT_WARM: begin
            nr = (r > 205) ? 255 : r + 10;
            ng = (g > 205) ? 255 : g + 25;
            nb = (b > 205) ? 255 : b - 5;
         end
         MODE_GRAY: begin
            nr = (r + g + b) / 3;
            ng = nr;
            nb = nr;
         end
         MODE_SEPIA: begin
            // Q10 weights, truncated
            nr = (402 * r + 787 * g + 194 * b) >> 10;
            ng = (357 * r + 702 * g + 172 * b) >> 10;
            nb = (279 * r + 547 * g + 134 * b) >> 10;
         end
         MODE_COOL: begin
            nr = r - 10;
            ng = g - 10;
            nb = b + 10;
         end
         MODE_WARM: begin
            nr = r + 20;
            ng = g + 5;
            nb = b - 10;
         end
         MODE_BANDS: begin
            if (row % 20 <= 5) begin
               nr = r + 20;
               ng = g + 10;
               nb = b - 10;
            end
         end
         MODE_FRAME: begin
            if (row >= 55 && row < h - 155 && col >= 55 && col < w - 55) begin
               nr = r - 30;
               ng = g - 30;
               nb = b - 20;
            end else begin
               nr = 255;
               ng = 255;
               nb = 255;
            end
         end
         MODE_CONTRAST_TINT: begin
            nr = contrast_boost(r) + 50;
            ng = contrast_boost(g) + 25;
            nb = contrast_boost(b) - 25;
         end
         MODE_CONTRAST_BLUE: begin
            nr = contrast_boost(r);
            ng = contrast_boost(g);
            nb = contrast_boost(b) + 50;
         end
         MODE_RED_BOOST:   nr = r + 50;
         MODE_GREEN_BOOST: ng = g + 50;
         MODE_BLUE_RED: begin
            nr = r - 50;
            nb = b + 150;
         end
         default: ;
      endcase
      res.red_out   = clamp_channel(nr);
      res.green_out = clamp_channel(ng);
      res.blue_out  = clamp_channel(nb);
      return res;
   endfunction

   function automatic logic [7:0] rand_channel();
      logic [7:0] v;
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0: v = 8'd0;
         1: v = 8'd1;
         2: v = 8'd100;
         3: v = 8'd101;
         4: v = 8'd127;
         5: v = 8'd128;
         6: v = 8'd205;
         7: v = 8'd206;
         8: v = 8'd254;
         default: v = 8'd255;
      endcase
      return v;
   endfunction

   function automatic int near_edge(int x);
      int v;
      v = x + $urandom_range(0, 4) - 2;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   // frame_end is the exclusive interior limit of the frame along this axis
   function automatic logic [11:0] pick_coord(int frame_end);
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 4095);
         1: v = near_edge(55);
         2: v = near_edge(frame_end);
         default: v = 20 * $urandom_range(0, 204) + $urandom_range(0, 7);
      endcase
      return 12'(v);
   endfunction

   function automatic logic [DIM_REG_W-1:0] pick_dim();
      logic [DIM_REG_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 13'd0;
         1: v = 13'd1;
         2: v = 13'(110 + $urandom_range(0, 2));
         3: v = 13'(210 + $urandom_range(0, 2));
         4: v = 13'd4096;
         5: v = 13'd8191;
         6: v = 13'($urandom_range(4097, 8190));
         default: v = 13'($urandom_range(200, 4096));
      endcase
      return v;
   endfunction

   task automatic flag_error(string msg);
      $display("ERROR @%0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic send_pixel(req_type px, bit typed, rsp_type want);
      int gap;
      gap = req_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      pending_pixels.push_back(typed ? want : filter_pixel(px, cur_mode, cur_width, cur_height));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         CSR_FILTER_MODE:  cur_mode   = val[MODE_W-1:0];
         CSR_IMAGE_WIDTH:  cur_width  = val;
         CSR_IMAGE_HEIGHT: cur_height = val;
         default: ;
      endcase
   endtask

   task automatic set_filter(logic [CSR_DATA_W-1:0] mode_word, logic [DIM_REG_W-1:0] w,
                             logic [DIM_REG_W-1:0] h);
      wait_idle();
      csr_write(CSR_FILTER_MODE, mode_word);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_pixels.size());
         $display("tb_rgb_pixel_color_filter_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            flag_error($sformatf("unexpected transaction %h", rsp_data));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.red_out !== want.red_out)
               flag_error($sformatf("#%0d red_out got %0d expected %0d", checked_count,
                                    rsp_data.red_out, want.red_out));
            if (rsp_data.green_out !== want.green_out)
               flag_error($sformatf("#%0d green_out got %0d expected %0d", checked_count,
                                    rsp_data.green_out, want.green_out));
            if (rsp_data.blue_out !== want.blue_out)
               flag_error($sformatf("#%0d blue_out got %0d expected %0d", checked_count,
                                    rsp_data.blue_out, want.blue_out));
            checked_count++;
         end
      end
   end

   // result side: per-transaction stall, plus one long hold on request
   initial begin : rsp_sink
      int wait_cycles;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = rsp_idle ? $urandom_range(0, 10) : 0;
         if (hold_rsp_req) begin
            wait_cycles += HOLD_CYCLES;
            hold_rsp_req = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      req_type              px;
      logic [MODE_W-1:0]    mode;
      logic [DIM_REG_W-1:0] w, h;
      int                   w_eff, h_eff;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cur_mode       = MODE_PASS;
      cur_width      = WIDTH_RESET;
      cur_height     = HEIGHT_RESET;
      mismatch_count = 0;
      checked_count  = 0;
      setting_count  = 0;
      cycle_count    = 0;
      req_idle       = 1'b1;
      rsp_idle       = 1'b1;
      hold_rsp_req   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         if (directed_cases[i].mode != cur_mode || directed_cases[i].width != cur_width ||
             directed_cases[i].height != cur_height)
            set_filter(CSR_DATA_W'(directed_cases[i].mode), directed_cases[i].width,
                       directed_cases[i].height);
         send_pixel(directed_cases[i].px, directed_cases[i].typed, directed_cases[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         mode = (phase < 16) ? MODE_W'(phase) : MODE_FRAME;
         if (phase == 16) begin
            w = 13'd1;
            h = 13'd1;
         end else begin
            w = pick_dim();
            h = pick_dim();
         end
         set_filter({9'($urandom_range(0, 511)), mode}, w, h);
         req_idle = (phase % 4 == 0) || (phase % 4 == 2);
         rsp_idle = (phase % 4 == 0) || (phase % 4 == 3);
         w_eff = (cur_width > DIM_LIMIT) ? DIM_LIMIT : int'(cur_width);
         h_eff = (cur_height > DIM_LIMIT) ? DIM_LIMIT : int'(cur_height);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == 10) hold_rsp_req = 1'b1;
            if (phase == 9 && i == 45) wait_idle();
            px.red_in    = rand_channel();
            px.green_in  = rand_channel();
            px.blue_in   = rand_channel();
            px.pixel_row = pick_coord(h_eff - 155);
            px.pixel_col = pick_coord(w_eff - 55);
            send_pixel(px, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("summary: %0d pixel transactions checked over %0d filter settings",
               checked_count, setting_count);
      $display("summary: all 16 mode codes, frame edges, long output hold and a full drain");
      if (mismatch_count == 0)
         $display("tb_rgb_pixel_color_filter_top: done, clean");
      else
         $display("tb_rgb_pixel_color_filter_top: done, errors");
      $finish;
   end

endmodule
